[rtl/per_channel_running_statistics_top_assert.svh]
// Assertion helpers shared by the statistics block.
`ifndef PER_CHANNEL_RUNNING_STATISTICS_TOP_ASSERT_SVH
`define PER_CHANNEL_RUNNING_STATISTICS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PCRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PCRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pcrs_pkg.sv]
package pcrs_pkg;

  // Field widths
  localparam int CH_W   = 7;
  localparam int SMP_W  = 32;
  localparam int SEEN_W = 24;
  localparam int N_W    = 25;
  localparam int DLT_W  = 33;
  localparam int SUM_W  = 64;
  localparam int ACC_W  = 66;
  localparam int TERM_W = 50;
  localparam int MLO_W  = 17;

  // Stream widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 104;

  // Serial divider: one quotient bit per cycle
  localparam int DIV_STEPS = DLT_W;
  localparam int CNT_W     = 6;

  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_MEAN,
    ST_D2,
    ST_MUL0,
    ST_MUL1,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

[rtl/per_channel_running_statistics_top.sv]
// Per-channel running mean and sum of squared deviations (Welford update).
// Input stream s_*: one transfer carries a channel number, a signed Q16.16
// sample and the number of samples already folded into that channel.
// Output stream m_*: exactly one transfer per input, in input order, with the
// channel, its updated Q16.16 mean and its saturating Q48.16 sum.
// Mean and sum live in two single-port-write memories with a registered
// read; each item does read, update and write-back of its entry.
// The update uses a 33-step restoring divider (one quotient bit per cycle).
// The next item is taken in the cycle after the write-back; the block does
// not accept a new item before the last one's write-back.
// After reset both memories are swept to zero, one entry per cycle, over
// all CHANNELS entries; s_tready stays low during that pass.
// A finished result sits in the output register until m_tready; the next
// item may start meanwhile, but its write-back and output load wait until
// the output register is free.
// Channel numbers at or above CHANNELS change no state and return zeros.
module per_channel_running_statistics_top #(
  parameter int CHANNELS = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [6:0] channel, [38:7] sample_value, [62:39] samples_seen, [63] zero
  input  logic [pcrs_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [6:0] channel_out, [38:7] mean_out, [102:39] spread_sum_out, [103] zero
  output logic [pcrs_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import pcrs_pkg::*;

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W  = 11;

  // Memories
  logic [SMP_W-1:0] mean_mem   [CHANNELS];
  logic [SUM_W-1:0] spread_mem [CHANNELS];
  logic [SMP_W-1:0] mean_rd;
  logic [SUM_W-1:0] spread_rd;

  // Control
  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_idx;
  logic [CNT_W-1:0]  div_cnt;
  logic              out_free;
  logic              out_load;
  logic              mem_we;
  logic              accept;

  // Input fields
  logic [CH_W-1:0]    in_ch;
  logic [EXT_W-1:0]   in_ch_ext;
  logic [ADDR_W-1:0]  in_addr;
  logic               in_range;

  // Datapath registers
  logic [CH_W-1:0]          ch_r;
  logic [ADDR_W-1:0]        addr_r;
  logic                     rng_r;
  logic signed [SMP_W-1:0]  sample_r;
  logic [N_W-1:0]           n_r;
  logic signed [SMP_W-1:0]  mean_r;
  logic [SUM_W-1:0]         spread_r;
  logic                     delta_neg;
  logic [DLT_W-1:0]         dmag;
  logic [DLT_W-1:0]         quo;
  logic [N_W-1:0]           rem;
  logic signed [SMP_W-1:0]  new_mean_r;
  logic [DLT_W-1:0]         d2mag;
  logic [ACC_W-1:0]         acc;
  logic [SUM_W-1:0]         sum_r;

  // Combinational datapath
  logic signed [DLT_W-1:0]  delta_w;
  logic [N_W+1:0]           trial;
  logic [DLT_W-1:0]         qs_w;
  logic [DLT_W:0]           nm_w;
  logic signed [DLT_W-1:0]  delta2_w;
  logic [SUM_W:0]           sum_w;
  logic [ADDR_W-1:0]        wr_addr;
  logic [SMP_W-1:0]         mean_wdata;
  logic [SUM_W-1:0]         spread_wdata;

  assign in_ch     = s_tdata[CH_W-1:0];
  assign in_ch_ext = {{(EXT_W-CH_W){1'b0}}, in_ch};
  assign in_addr   = in_ch_ext[ADDR_W-1:0];
  assign in_range  = in_ch_ext < EXT_W'(CHANNELS);
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Next state and handshake
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx == ADDR_W'(CHANNELS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) state_next = in_range ? ST_READ : ST_DONE;
      end
      ST_READ: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == '0) state_next = ST_MEAN;
      end
      ST_MEAN: state_next = ST_D2;
      ST_D2:   state_next = ST_MUL0;
      ST_MUL0: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_SUM;
      ST_SUM:  state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          mem_we     = rng_r;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Clearing sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Memory write port: sweep or write-back
  assign wr_addr      = (state == ST_CLEAR) ? clr_idx : addr_r;
  assign mean_wdata   = (state == ST_CLEAR) ? '0 : new_mean_r;
  assign spread_wdata = (state == ST_CLEAR) ? '0 : sum_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mean_mem[wr_addr]   <= mean_wdata;
      spread_mem[wr_addr] <= spread_wdata;
    end
  end

  // Registered read, addressed by the incoming channel
  always_ff @(posedge clk) begin
    mean_rd   <= mean_mem[in_addr];
    spread_rd <= spread_mem[in_addr];
  end

  // Arithmetic steps
  assign delta_w  = {sample_r[SMP_W-1], sample_r}
                  - {mean_rd[SMP_W-1], mean_rd};
  assign trial    = {1'b0, rem, quo[DLT_W-1]} - {2'b00, n_r};
  assign qs_w     = delta_neg ? (~quo + 1'b1) : quo;
  assign nm_w     = {{2{mean_r[SMP_W-1]}}, mean_r} + {qs_w[DLT_W-1], qs_w};
  assign delta2_w = {sample_r[SMP_W-1], sample_r}
                  - {new_mean_r[SMP_W-1], new_mean_r};
  assign sum_w    = {spread_r[SUM_W-1], spread_r}
                  + {{(SUM_W+1-TERM_W){1'b0}}, acc[ACC_W-1:16]};

  // Datapath sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ch_r       <= in_ch;
            addr_r     <= in_addr;
            rng_r      <= in_range;
            sample_r   <= s_tdata[CH_W +: SMP_W];
            n_r        <= {1'b0, s_tdata[CH_W+SMP_W +: SEEN_W]} + 1'b1;
            new_mean_r <= '0;
            sum_r      <= '0;
          end
        end
        ST_READ: begin
          mean_r    <= mean_rd;
          spread_r  <= spread_rd;
          delta_neg <= delta_w[DLT_W-1];
          dmag      <= delta_w[DLT_W-1] ? (~delta_w + 1'b1) : delta_w;
          quo       <= delta_w[DLT_W-1] ? (~delta_w + 1'b1) : delta_w;
          rem       <= '0;
          div_cnt   <= CNT_W'(DIV_STEPS - 1);
        end
        ST_DIV: begin
          if (!trial[N_W+1]) rem <= trial[N_W-1:0];
          else               rem <= {rem[N_W-2:0], quo[DLT_W-1]};
          quo     <= {quo[DLT_W-2:0], !trial[N_W+1]};
          div_cnt <= div_cnt - 1'b1;
        end
        ST_MEAN: new_mean_r <= nm_w[SMP_W-1:0];
        ST_D2:   d2mag <= delta2_w[DLT_W-1] ? (~delta2_w + 1'b1) : delta2_w;
        ST_MUL0: acc <= ACC_W'(dmag * d2mag[MLO_W-1:0]);
        ST_MUL1: acc <= acc + (ACC_W'(dmag * d2mag[DLT_W-1:MLO_W]) << MLO_W);
        ST_SUM:  sum_r <= (sum_w[SUM_W] != sum_w[SUM_W-1]) ? SUM_MAX : sum_w[SUM_W-1:0];
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {1'b0, sum_r, new_mean_r, ch_r};
  end

  // Checks
  `include "per_channel_running_statistics_top_assert.svh"

  `PCRS_ASSERT_IMP(a_div_rem, state == ST_MEAN, rem < n_r, "divider remainder not below divisor")
  `PCRS_ASSERT_IMP(a_prod_fit, state == ST_SUM, acc[ACC_W-1:SUM_W] == '0, "product exceeds 64 bits")
  `PCRS_ASSERT_IMP(a_mean_between, state == ST_D2, (sample_r >= mean_r) ? (new_mean_r >= mean_r && new_mean_r <= sample_r) : (new_mean_r <= mean_r && new_mean_r >= sample_r), "new mean outside old mean and sample")
  `PCRS_ASSERT_NXT(a_one_result, out_load, state == ST_IDLE && m_tvalid, "result load did not return to idle")

endmodule

[tb/sv/tb_per_channel_running_statistics_top.sv]
`timescale 1ns / 1ps

module tb_per_channel_running_statistics_top;
  import pcrs_pkg::*;

  localparam int NCH = 128;
  // channel fed a run of extreme samples, so each step adds a near-maximal term
  localparam int SAT_CH = 9;
  localparam int SAT_ITEMS = 200;
  localparam int RAND_ITEMS = 830;
  localparam int DRAIN_CYCLES = 100;
  localparam longint CYCLE_LIMIT = 500000;
  localparam logic [SEEN_W-1:0] SEEN_TOP = '1;
  localparam logic signed [SMP_W-1:0] SMP_TOP = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_BOT = {1'b1, {(SMP_W-1){1'b0}}};

  // one expected output transfer
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] mean;
    logic [SUM_W-1:0] spread;
  } stat_update_t;

  // Per-channel mean / spread-sum tracker and result checker
  class stats_board;
    logic signed [SMP_W-1:0] mean_tab [NCH];
    logic signed [SUM_W-1:0] spread_tab [NCH];
    stat_update_t pending_updates [$];
    int errors;

    function new();
      for (int i = 0; i < NCH; i++) begin
        mean_tab[i] = '0;
        spread_tab[i] = '0;
      end
      errors = 0;
    endfunction

    // Welford step for one accepted sample; queue the update it must produce
    function void note_sample(logic [CH_W-1:0] ch, logic signed [SMP_W-1:0] smp,
                              logic [SEEN_W-1:0] seen);
      longint smp_l, old_mean, cnt, delta, new_mean, delta2, spread, lim;
      logic [63:0] mag_d, mag_d2, term;
      stat_update_t upd;
      smp_l = smp;
      old_mean = mean_tab[ch];
      cnt = seen;
      cnt = cnt + 1;
      delta = smp_l - old_mean;
      // signed divide truncates toward zero
      new_mean = old_mean + delta / cnt;
      delta2 = smp_l - new_mean;
      mag_d = (delta < 0) ? -delta : delta;
      mag_d2 = (delta2 < 0) ? -delta2 : delta2;
      // both factors share a sign, so the product is a plain magnitude
      term = (mag_d * mag_d2) >> 16;
      spread = spread_tab[ch];
      lim = SUM_MAX;
      if (spread > lim - $signed(term))
        spread = lim;
      else
        spread = spread + $signed(term);
      mean_tab[ch] = new_mean[SMP_W-1:0];
      spread_tab[ch] = spread;
      upd.ch = ch;
      upd.mean = new_mean[SMP_W-1:0];
      upd.spread = spread;
      pending_updates.push_back(upd);
    endfunction

    // Compare one output transfer with the oldest queued update
    function void check_update(logic [OUT_TDATA_W-1:0] data);
      stat_update_t want;
      logic [CH_W-1:0] got_ch;
      logic [SMP_W-1:0] got_mean;
      logic [SUM_W-1:0] got_spread;
      got_ch = data[CH_W-1:0];
      got_mean = data[CH_W +: SMP_W];
      got_spread = data[CH_W+SMP_W +: SUM_W];
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result ch=%0d mean=%h sum=%h",
                 $time, got_ch, got_mean, got_spread);
        errors++;
        return;
      end
      want = pending_updates.pop_front();
      if (got_ch !== want.ch) begin
        $display("%0t: channel_out mismatch: expected %0d, got %0d",
                 $time, want.ch, got_ch);
        errors++;
      end
      if (got_mean !== want.mean) begin
        $display("%0t: mean_out mismatch on ch %0d: expected %h, got %h",
                 $time, want.ch, want.mean, got_mean);
        errors++;
      end
      if (got_spread !== want.spread) begin
        $display("%0t: spread_sum_out mismatch on ch %0d: expected %h, got %h",
                 $time, want.ch, want.spread, got_spread);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  stats_board board;
  bit idle_on = 1'b1;
  longint cycle_cnt = 0;

  per_channel_running_statistics_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // result side: random backpressure while idle_on is set, else always ready
  always @(negedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_update(m_tdata);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_per_channel_running_statistics_top: FAIL");
      $finish;
    end
  end

  // one sample transfer, with optional idle cycles ahead of it
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] smp,
                             input logic [SEEN_W-1:0] seen);
    while (idle_on && $urandom_range(99) < 16) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, seen, smp, ch};
    do @(posedge clk); while (!s_tready);
    board.note_sample(ch, smp, seen);
  endtask

  // drop valid and hold until every queued update has come back
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending_updates.size() != 0) @(posedge clk);
  endtask

  initial begin
    int seen_cnt [NCH];
    int base [NCH];
    logic [CH_W-1:0] ch;
    logic signed [SMP_W-1:0] smp;
    logic [SEEN_W-1:0] seen;
    int unsigned pick;

    board = new();
    for (int i = 0; i < NCH; i++) begin
      seen_cnt[i] = 0;
      base[i] = int'($urandom) >>> $urandom_range(12);
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, truncation toward zero, fractions
    send_sample(7'd0, SMP_TOP, '0);
    send_sample(7'd0, SMP_BOT, SEEN_TOP);
    send_sample(7'd127, SMP_BOT, '0);
    send_sample(7'd127, SMP_TOP, SEEN_TOP);
    send_sample(7'd127, SMP_TOP, 24'd1);
    send_sample(7'd1, -32'sd1, 24'd0);
    send_sample(7'd1, 32'sd1, 24'd1);
    send_sample(7'd2, -32'sd3, 24'd2);
    send_sample(7'd2, -32'sd5, 24'd3);
    send_sample(7'd3, -32'sd7, 24'd1);
    send_sample(7'd3, 32'sd7, 24'd3);
    send_sample(7'd4, 32'sh0001_8000, 24'd0);
    send_sample(7'd4, 32'sh0002_0000, 24'd1);
    send_sample(7'd4, -32'sh0000_4000, 24'd2);
    send_sample(7'd126, 32'sd0, 24'd0);
    send_sample(7'd126, 32'sd0, SEEN_TOP);
    send_sample(7'd5, SMP_TOP, 24'd0);
    send_sample(7'd5, SMP_TOP, 24'd7);
    wait_drained();

    // Large terms: mean pinned at the bottom, then the top sample with a
    // huge count, so each step adds close to the largest possible term.
    // No idling on either side here.
    idle_on = 1'b0;
    send_sample(CH_W'(SAT_CH), SMP_BOT, '0);
    for (int i = 0; i < SAT_ITEMS; i++)
      send_sample(CH_W'(SAT_CH), SMP_TOP, SEEN_TOP);
    idle_on = 1'b1;

    // Random: mostly running counts per channel with samples near a
    // per-channel level, plus raw samples and arbitrary counts
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2)
        wait_drained();
      ch = CH_W'($urandom_range(NCH - 1));
      pick = $urandom_range(99);
      if (pick < 15)
        smp = $urandom;
      else
        smp = base[ch] + int'($urandom_range(1 << 20)) - (1 << 19);
      if (pick >= 15 && pick < 25)
        seen = SEEN_W'($urandom);
      else if (pick >= 25 && pick < 30)
        seen = SEEN_TOP;
      else
        seen = SEEN_W'(seen_cnt[ch]);
      if (seen_cnt[ch] < SEEN_TOP)
        seen_cnt[ch]++;
      send_sample(ch, smp, seen);
    end

    // drain and finish
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending_updates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0)
      $display("tb_per_channel_running_statistics_top: PASS");
    else
      $display("tb_per_channel_running_statistics_top: FAIL");
    $finish;
  end

endmodule
